@@ rtl/core/ctsch_pkg.sv @@
// Package: shared types and constants for the cooperative tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package ctsch_pkg;

	localparam int MAX_TASKS_DEF = 8;
	localparam int DELAY_W       = 32;
	localparam int PEND_W        = 7;
	localparam int SLOT_W        = 3;
	localparam logic [PEND_W-1:0] PENDING_MAX = 7'd127;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_ADD      = 2'd2,
		OP_DELETE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_FINISH,
		ST_ADD
	} state_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] period;
		logic [PEND_W-1:0]  pending;
	} slot_rec_t;

endpackage

`default_nettype wire

@@ rtl/core/cooperative_tick_scheduler.sv @@
// Top level: cooperative tick scheduler with a slot table in block memory.
//
// channel   direction  handshake                 payload
// command   in         start & !busy             operation, slot_number, first_delay, run_period
// result    out        result_valid (one cycle)  task_slot, has_task, status, last_result
//
// Tick and dispatch walk the slot memory one entry per cycle (read, update, write back),
// then pass through ST_FLUSH and ST_FINISH; the last result is registered from ST_FINISH.
// Add scans the in-use bits one per cycle and stays busy until a free slot or the last slot.
// Delete completes at once: result next cycle, busy stays low.
// Reset clears the in-use bits; record memory needs no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module cooperative_tick_scheduler import ctsch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          operation,
	input  wire logic [SLOT_W-1:0]   slot_number,
	input  wire logic [DELAY_W-1:0]  first_delay,
	input  wire logic [DELAY_W-1:0]  run_period,
	output logic                     result_valid,
	output logic [SLOT_W-1:0]        task_slot,
	output logic                     has_task,
	output logic                     status,
	output logic                     last_result
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int EXT_W = IDX_W + SLOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	state_t state_q, state_d;
	op_t    op_q;

	logic [DELAY_W-1:0]   first_q;
	logic [DELAY_W-1:0]   period_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [MAX_TASKS-1:0] in_use_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 hold_valid_q;
	logic [IDX_W-1:0]     hold_idx_q;

	logic             rd_en, rd_clear, advance, hold_load, use_set, use_clr;
	logic [IDX_W-1:0] use_idx;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	slot_rec_t        ram_wdata, ram_rdata;
	logic             emit, emit_has, emit_stat, emit_last;
	logic [IDX_W-1:0] emit_idx;
	logic [EXT_W-1:0] emit_ext, del_ext;
	logic             del_ok;

	ctsch_slot_ram #(
		.DEPTH (MAX_TASKS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign busy     = (state_q != ST_IDLE);
	assign del_ext  = {{IDX_W{1'b0}}, slot_number};
	assign del_ok   = del_ext < EXT_W'(MAX_TASKS);
	assign emit_ext = {{SLOT_W{1'b0}}, emit_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_clear  = 1'b0;
		advance   = 1'b0;
		hold_load = 1'b0;
		use_set   = 1'b0;
		use_clr   = 1'b0;
		use_idx   = rd_idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = ram_rdata;
		emit      = 1'b0;
		emit_idx  = '0;
		emit_has  = 1'b0;
		emit_stat = 1'b0;
		emit_last = 1'b0;

		// stage 1: read data back from memory, update, write back
		if (valid_s1) begin
			if (op_q == OP_TICK) begin
				if (in_use_q[idx_s1]) begin
					ram_we = 1'b1;
					if (ram_rdata.delay == '0) begin
						ram_wdata.delay = ram_rdata.period - DELAY_W'(1);
						if (ram_rdata.pending != PENDING_MAX) begin
							ram_wdata.pending = ram_rdata.pending + PEND_W'(1);
						end
					end else begin
						ram_wdata.delay = ram_rdata.delay - DELAY_W'(1);
					end
				end
			end else if (in_use_q[idx_s1] && (ram_rdata.pending != '0)) begin
				ram_we            = 1'b1;
				ram_wdata.pending = ram_rdata.pending - PEND_W'(1);
				hold_load         = 1'b1;
				if (hold_valid_q) begin
					emit     = 1'b1;
					emit_idx = hold_idx_q;
					emit_has = 1'b1;
				end
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op_t'(operation))
						OP_TICK, OP_DISPATCH: begin
							rd_clear = 1'b1;
							state_d  = ST_WALK;
						end
						OP_ADD: begin
							rd_clear = 1'b1;
							state_d  = ST_ADD;
						end
						OP_DELETE: begin
							use_clr   = del_ok;
							use_idx   = del_ext[IDX_W-1:0];
							emit      = 1'b1;
							emit_last = 1'b1;
						end
					endcase
				end
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_FLUSH;
				end else begin
					advance = 1'b1;
				end
			end
			ST_FLUSH: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				if (op_q == OP_DISPATCH && hold_valid_q) begin
					emit_idx = hold_idx_q;
					emit_has = 1'b1;
				end
				state_d = ST_IDLE;
			end
			ST_ADD: begin
				if (!in_use_q[rd_idx_q]) begin
					ram_we    = 1'b1;
					ram_waddr = rd_idx_q;
					ram_wdata = '{delay: first_q, period: period_q, pending: '0};
					use_set   = 1'b1;
					emit      = 1'b1;
					emit_idx  = rd_idx_q;
					emit_has  = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end else if (rd_idx_q == LAST_IDX) begin
					emit      = 1'b1;
					emit_stat = 1'b1;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					advance = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			valid_s1     <= 1'b0;
			hold_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			valid_s1     <= rd_en;
			result_valid <= emit;
			if (use_set) begin
				in_use_q[use_idx] <= 1'b1;
			end else if (use_clr) begin
				in_use_q[use_idx] <= 1'b0;
			end
			if (rd_clear) begin
				hold_valid_q <= 1'b0;
			end else if (hold_load) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q     <= op_t'(operation);
			first_q  <= first_delay;
			period_q <= run_period;
		end
		if (rd_clear) begin
			rd_idx_q <= '0;
		end else if (advance) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		idx_s1 <= rd_idx_q;
		if (hold_load) begin
			hold_idx_q <= idx_s1;
		end
		task_slot   <= emit_ext[SLOT_W-1:0];
		has_task    <= emit_has;
		status      <= emit_stat;
		last_result <= emit_last;
	end

endmodule

`default_nettype wire

@@ rtl/core/ctsch_slot_ram.sv @@
// Slot record memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ctsch_slot_ram import ctsch_pkg::*; #(
	parameter int DEPTH = MAX_TASKS_DEF,
	parameter int IDX_W = 3
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [IDX_W-1:0]  waddr,
	input  wire slot_rec_t         wdata,
	input  wire logic              re,
	input  wire logic [IDX_W-1:0]  raddr,
	output slot_rec_t              rdata
);

	slot_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ctsch_checker.sv @@
// Port-level checker for the cooperative tick scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ctsch_checker import ctsch_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  operation,
	input wire logic        result_valid,
	input wire logic        has_task,
	input wire logic        status,
	input wire logic        last_result
);

	a_full_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> !has_task && last_result)
		else $error("table-full result carries a task or is not last");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_task |-> last_result)
		else $error("result without task is not the last item");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> !busy)
		else $error("final result shown while still busy");

	a_delete_now: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_DELETE) |=>
			result_valid && last_result && !has_task && !busy)
		else $error("delete did not complete in one cycle");

	a_tick_walks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_TICK) |=> busy && !result_valid)
		else $error("tick did not start a table walk");

endmodule

bind cooperative_tick_scheduler ctsch_checker u_ctsch_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.result_valid (result_valid),
	.has_task     (has_task),
	.status       (status),
	.last_result  (last_result)
);

`default_nettype wire

@@ tb/ctsch_checker.sv @@
// Scoreboard: slot table predictor and result comparison for the cooperative tick scheduler.
`timescale 1ns / 1ps

module ctsch_scoreboard import ctsch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [1:0]         operation,
	input  wire logic [SLOT_W-1:0]  slot_number,
	input  wire logic [DELAY_W-1:0] first_delay,
	input  wire logic [DELAY_W-1:0] run_period,
	input  wire logic               result_valid,
	input  wire logic [SLOT_W-1:0]  task_slot,
	input  wire logic               has_task,
	input  wire logic               status,
	input  wire logic               last_result,
	output int                      errors,
	output int                      awaited,
	output int                      runs_dispatched,
	output int                      full_reports,
	output int                      saturated_hits
);

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              has;
		logic              stat;
		logic              last;
	} sched_result_t;

	sched_result_t awaited_results[$];

	bit                 in_use[MAX_TASKS];
	logic [DELAY_W-1:0] delay_q[MAX_TASKS];
	logic [DELAY_W-1:0] period_q[MAX_TASKS];
	logic [PEND_W-1:0]  runs_q[MAX_TASKS];

	int err_count;
	int run_count;
	int full_count;
	int sat_count;

	function automatic void push_result(input logic [SLOT_W-1:0] slot, input logic has,
			input logic stat, input logic last);
		sched_result_t r;
		r.slot = slot;
		r.has  = has;
		r.stat = stat;
		r.last = last;
		awaited_results.push_back(r);
	endfunction

	function automatic void clear_slot(input int i);
		in_use[i]   = 1'b0;
		delay_q[i]  = '0;
		period_q[i] = '0;
		runs_q[i]   = '0;
	endfunction

	task automatic apply_sched_op(input op_t op, input logic [SLOT_W-1:0] sel,
			input logic [DELAY_W-1:0] first, input logic [DELAY_W-1:0] period);
		int i;
		int due;
		int k;
		int free_idx;
		case (op)
			OP_TICK: begin
				for (i = 0; i < MAX_TASKS; i++) begin
					if (in_use[i]) begin
						if (delay_q[i] == '0) begin
							if (runs_q[i] < PENDING_MAX)
								runs_q[i] = runs_q[i] + PEND_W'(1);
							else
								sat_count++;
							delay_q[i] = period_q[i] - DELAY_W'(1);
						end else begin
							delay_q[i] = delay_q[i] - DELAY_W'(1);
						end
					end
				end
				push_result('0, 1'b0, 1'b0, 1'b1);
			end
			OP_DISPATCH: begin
				due = 0;
				for (i = 0; i < MAX_TASKS; i++)
					if (in_use[i] && runs_q[i] != '0)
						due++;
				if (due == 0) begin
					push_result('0, 1'b0, 1'b0, 1'b1);
				end else begin
					k = 0;
					for (i = 0; i < MAX_TASKS; i++) begin
						if (in_use[i] && runs_q[i] != '0) begin
							runs_q[i] = runs_q[i] - PEND_W'(1);
							k++;
							run_count++;
							push_result(SLOT_W'(i), 1'b1, 1'b0, k == due);
						end
					end
				end
			end
			OP_ADD: begin
				free_idx = -1;
				for (i = MAX_TASKS - 1; i >= 0; i--)
					if (!in_use[i])
						free_idx = i;
				if (free_idx < 0) begin
					full_count++;
					push_result('0, 1'b0, 1'b1, 1'b1);
				end else begin
					in_use[free_idx]   = 1'b1;
					delay_q[free_idx]  = first;
					period_q[free_idx] = period;
					runs_q[free_idx]   = '0;
					push_result(SLOT_W'(free_idx), 1'b1, 1'b0, 1'b1);
				end
			end
			default: begin
				if (int'(sel) < MAX_TASKS)
					clear_slot(int'(sel));
				push_result('0, 1'b0, 1'b0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sched_result_t exp;
		int i;
		if (!arst_n) begin
			for (i = 0; i < MAX_TASKS; i++)
				clear_slot(i);
			awaited_results.delete();
			err_count  = 0;
			run_count  = 0;
			full_count = 0;
			sat_count  = 0;
		end else begin
			if (start && !busy)
				apply_sched_op(op_t'(operation), slot_number, first_delay, run_period);
			if (result_valid) begin
				if (awaited_results.size() == 0) begin
					err_count++;
					$error("result with no item awaiting it: task_slot %0d has_task %0b",
						task_slot, has_task);
				end else begin
					exp = awaited_results.pop_front();
					if (task_slot !== exp.slot) begin
						err_count++;
						$error("task_slot: expected %0d, actual %0d", exp.slot, task_slot);
					end
					if (has_task !== exp.has) begin
						err_count++;
						$error("has_task: expected %0b, actual %0b", exp.has, has_task);
					end
					if (status !== exp.stat) begin
						err_count++;
						$error("status: expected %0b, actual %0b", exp.stat, status);
					end
					if (last_result !== exp.last) begin
						err_count++;
						$error("last_result: expected %0b, actual %0b", exp.last, last_result);
					end
				end
			end
		end
		errors          <= err_count;
		awaited         <= awaited_results.size();
		runs_dispatched <= run_count;
		full_reports    <= full_count;
		saturated_hits  <= sat_count;
	end

endmodule

@@ tb/tb_cooperative_tick_scheduler.sv @@
// Testbench top: command stimulus and verdict for the cooperative tick scheduler.
`timescale 1ns / 1ps

module tb_cooperative_tick_scheduler;
	import ctsch_pkg::*;

	localparam int RANDOM_ITEMS = 370;
	localparam int CYCLE_LIMIT  = 200000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic [1:0]          operation;
	logic [SLOT_W-1:0]   slot_number;
	logic [DELAY_W-1:0]  first_delay;
	logic [DELAY_W-1:0]  run_period;
	logic                busy;
	logic                result_valid;
	logic [SLOT_W-1:0]   task_slot;
	logic                has_task;
	logic                status;
	logic                last_result;

	int errors;
	int awaited;
	int runs_dispatched;
	int full_reports;
	int saturated_hits;

	int sent;
	int op_count[4];
	bit no_idle;

	cooperative_tick_scheduler uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.slot_number  (slot_number),
		.first_delay  (first_delay),
		.run_period   (run_period),
		.result_valid (result_valid),
		.task_slot    (task_slot),
		.has_task     (has_task),
		.status       (status),
		.last_result  (last_result)
	);

	ctsch_scoreboard u_scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.slot_number     (slot_number),
		.first_delay     (first_delay),
		.run_period      (run_period),
		.result_valid    (result_valid),
		.task_slot       (task_slot),
		.has_task        (has_task),
		.status          (status),
		.last_result     (last_result),
		.errors          (errors),
		.awaited         (awaited),
		.runs_dispatched (runs_dispatched),
		.full_reports    (full_reports),
		.saturated_hits  (saturated_hits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, awaited);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	function automatic logic [DELAY_W-1:0] small_val();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(0, 6);
		else if (r < 9)
			return $urandom_range(0, 40);
		else
			return $urandom();
	endfunction

	task automatic send(input op_t op, input int sel,
			input logic [DELAY_W-1:0] first, input logic [DELAY_W-1:0] period);
		int gap;
		@(negedge clk);
		start       = 1'b1;
		operation   = op;
		slot_number = SLOT_W'(sel);
		first_delay = first;
		run_period  = period;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		op_count[op]++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start       = 1'b0;
			operation   = 2'($urandom_range(0, 3));
			slot_number = SLOT_W'($urandom());
			first_delay = $urandom();
			run_period  = $urandom();
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	initial begin
		int base;
		int i;
		int r;
		bit sat_done;
		start       = 1'b0;
		operation   = OP_TICK;
		slot_number = '0;
		first_delay = '0;
		run_period  = '0;
		arst_n      = 1'b0;
		sent        = 0;
		no_idle     = 1'b0;
		sat_done    = 1'b0;
		for (i = 0; i < 4; i++)
			op_count[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, zero and all-ones periods, full table, reuse
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
		send(OP_ADD, $urandom(), 32'd0, 32'd0);
		send(OP_ADD, $urandom(), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(OP_ADD, $urandom(), 32'd1, 32'd1);
		send(OP_ADD, $urandom(), 32'd0, 32'd2);
		for (i = 0; i < 4; i++)
			send(OP_ADD, $urandom(), i, 32'd1);
		send(OP_ADD, $urandom(), 32'd3, 32'd3);
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
		send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
		send(OP_DELETE, 1, $urandom(), $urandom());
		send(OP_DELETE, 1, $urandom(), $urandom());
		send(OP_ADD, $urandom(), 32'd2, 32'd0);
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_TICK, $urandom(), $urandom(), $urandom());
		send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
		send(OP_DELETE, 7, $urandom(), $urandom());
		send(OP_DELETE, 0, $urandom(), $urandom());

		base = sent;
		while (sent - base < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (!sat_done && sent - base > 60) begin
				// run count saturation: one slot due on every tick, dispatched only after the ticks
				sat_done = 1'b1;
				for (i = 0; i < MAX_TASKS_DEF; i++)
					send(OP_DELETE, i, $urandom(), $urandom());
				send(OP_ADD, $urandom(), 32'd0, 32'd1);
				repeat (132) send(OP_TICK, $urandom(), $urandom(), $urandom());
				repeat (2) send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
			end else if (r < 7) begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 5))
						send(OP_DELETE, $urandom(), $urandom(), $urandom());
				repeat ($urandom_range(1, 4))
					send(OP_ADD, $urandom(), small_val(), small_val());
				repeat ($urandom_range(4, 14)) begin
					r = $urandom_range(0, 9);
					if (r < 5)
						send(OP_TICK, $urandom(), $urandom(), $urandom());
					else if (r < 9)
						send(OP_DISPATCH, $urandom(), $urandom(), $urandom());
					else
						send(OP_DELETE, $urandom(), $urandom(), $urandom());
				end
			end else begin
				repeat ($urandom_range(3, 10))
					send(op_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (awaited != 0)
			@(posedge clk);
		repeat (MAX_TASKS_DEF + 6) @(posedge clk);

		$display("ran %0d items: %0d ticks, %0d dispatches, %0d adds, %0d deletes",
			sent, op_count[OP_TICK], op_count[OP_DISPATCH], op_count[OP_ADD],
			op_count[OP_DELETE]);
		$display("%0d task runs dispatched, %0d adds on a full table, %0d saturated ticks",
			runs_dispatched, full_reports, saturated_hits);
		if (errors == 0 && awaited == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ctsch_pkg.sv
rtl/core/ctsch_slot_ram.sv
rtl/core/cooperative_tick_scheduler.sv
rtl/core/ctsch_checker.sv
tb/ctsch_checker.sv
tb/tb_cooperative_tick_scheduler.sv
